FILE: design/ppe_pkg.sv
`default_nettype none

package ppe_pkg;

    localparam int C_CFG_INDEX_W = 3;
    localparam int C_CFG_DATA_W  = 15;

    localparam logic [C_CFG_INDEX_W-1:0] C_REG_OUTPUT_MODE       = 3'd0;
    localparam logic [C_CFG_INDEX_W-1:0] C_REG_TRANSPARENT_INDEX = 3'd1;
    localparam logic [C_CFG_INDEX_W-1:0] C_REG_IMAGE_WIDTH       = 3'd2;
    localparam logic [C_CFG_INDEX_W-1:0] C_REG_IMAGE_HEIGHT      = 3'd3;
    localparam logic [C_CFG_INDEX_W-1:0] C_REG_LINE_STRIDE_BYTES = 3'd4;
    localparam logic [C_CFG_INDEX_W-1:0] C_REG_PIXEL_STRIDE_BITS = 3'd5;

    typedef logic [1:0] t_mode;
    localparam t_mode C_MODE_RGB16 = 2'd0;
    localparam t_mode C_MODE_RGB24 = 2'd1;
    localparam t_mode C_MODE_MONO  = 2'd2;

    localparam logic C_OP_PALETTE = 1'b0;
    localparam logic C_OP_PIXEL   = 1'b1;

    typedef logic [1:0] t_count;
    localparam t_count C_COUNT_MONO  = 2'd1;
    localparam t_count C_COUNT_RGB16 = 2'd2;
    localparam t_count C_COUNT_RGB24 = 2'd3;

    localparam logic [15:0] C_BLACK_RGB16 = 16'h0841;
    localparam logic [23:0] C_BLACK_RGB24 = 24'h010101;

endpackage

`default_nettype wire

FILE: design/ppe_ram.sv
`default_nettype none

module ppe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: design/palette_pixel_expander.sv
`default_nettype none

// Channel   Direction  Handshake                  Payload
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
// item      in         i_in_valid / o_in_ready    i_opcode, i_entry_*, i_pixel_code
// result    out        o_out_valid / i_out_ready  o_byte_address, o_out_bytes,
//                                                 o_byte_count, o_row_done, o_frame_done
//
// One transaction per cycle on the item channel while o_in_ready is high; a pixel
// result is registered in the palette RAM read and read stage, then in the output
// register. A palette write is visible to any pixel accepted on a later cycle.
// Reset clears counters, row base, mono byte and configuration; the palette RAM is
// not cleared and needs no clearing pass.
// A stalled output holds one result while the read stage holds the next pixel.

module palette_pixel_expander #(
    parameter int PALETTE_DEPTH = 256,
    parameter int ADDRESS_BITS  = 26
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,

    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [ppe_pkg::C_CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [ppe_pkg::C_CFG_DATA_W-1:0]   i_cfg_data,

    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_opcode,
    input  wire logic [7:0]                         i_entry_slot,
    input  wire logic [7:0]                         i_entry_red,
    input  wire logic [7:0]                         i_entry_green,
    input  wire logic [7:0]                         i_entry_blue,
    input  wire logic [7:0]                         i_pixel_code,

    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [ADDRESS_BITS-1:0]                 o_byte_address,
    output logic [23:0]                             o_out_bytes,
    output ppe_pkg::t_count                         o_byte_count,
    output logic                                    o_row_done,
    output logic                                    o_frame_done
);

    import ppe_pkg::*;

    localparam int          IDX_W   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [12:0] MAX_DIM = 13'd4096;

    t_mode              r_cfg_mode;
    logic [7:0]         r_cfg_trans;
    logic [12:0]        r_cfg_width;
    logic [12:0]        r_cfg_height;
    logic [14:0]        r_cfg_stride;
    logic [5:0]         r_cfg_pbits;

    logic [11:0]        r_col, n_col;
    logic [11:0]        r_row, n_row;
    logic [ADDRESS_BITS-1:0] r_base, n_base;
    logic [7:0]         r_acc, n_acc;

    logic               r_s1_valid, n_s1_valid;
    logic               r_s1_emit;
    logic               r_s1_trans;
    logic               r_s1_inrange;
    logic [7:0]         r_s1_mono;
    logic [ADDRESS_BITS-1:0] r_s1_addr;
    logic               r_s1_row_end;
    logic               r_s1_frame_end;

    logic               r_out_valid, n_out_valid;
    logic [ADDRESS_BITS-1:0] r_out_addr;
    logic [23:0]        r_out_bytes;
    t_count             r_out_count;
    logic               r_out_row;
    logic               r_out_frame;

    logic               in_acc, pal_we, pix_acc;
    logic               out_free, s1_go, s1_load_out;
    logic [12:0]        width_c, height_c, x_next, y_next;
    logic               row_end, frame_end, is_mono, code_trans, emit;
    logic [17:0]        prod;
    logic [ADDRESS_BITS-1:0] offset, addr;
    logic [7:0]         acc_set;
    logic [23:0]        ram_rdata, color, bytes;
    logic [4:0]         r5, g5, b5;
    t_count             count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= C_MODE_RGB16;
            r_cfg_trans  <= 8'd0;
            r_cfg_width  <= 13'd1;
            r_cfg_height <= 13'd1;
            r_cfg_stride <= 15'd1;
            r_cfg_pbits  <= 6'd24;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                C_REG_OUTPUT_MODE:       r_cfg_mode   <= i_cfg_data[1:0];
                C_REG_TRANSPARENT_INDEX: r_cfg_trans  <= i_cfg_data[7:0];
                C_REG_IMAGE_WIDTH:       r_cfg_width  <= i_cfg_data[12:0];
                C_REG_IMAGE_HEIGHT:      r_cfg_height <= i_cfg_data[12:0];
                C_REG_LINE_STRIDE_BYTES: r_cfg_stride <= i_cfg_data[14:0];
                C_REG_PIXEL_STRIDE_BITS: r_cfg_pbits  <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_go       = r_s1_valid && (!r_s1_emit || out_free);
    assign s1_load_out = s1_go && r_s1_emit;
    assign o_in_ready  = !r_s1_valid || s1_go;
    assign in_acc      = i_in_valid && o_in_ready;
    assign pix_acc     = in_acc && (i_opcode == C_OP_PIXEL);
    assign pal_we      = in_acc && (i_opcode == C_OP_PALETTE)
                         && (32'(i_entry_slot) < PALETTE_DEPTH);

    ppe_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (i_entry_slot[IDX_W-1:0]),
        .i_wdata ({i_entry_red, i_entry_green, i_entry_blue}),
        .i_re    (pix_acc),
        .i_raddr (i_pixel_code[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        width_c  = (r_cfg_width == 13'd0) ? 13'd1
                 : ((r_cfg_width > MAX_DIM) ? MAX_DIM : r_cfg_width);
        height_c = (r_cfg_height == 13'd0) ? 13'd1
                 : ((r_cfg_height > MAX_DIM) ? MAX_DIM : r_cfg_height);
        x_next    = {1'b0, r_col} + 13'd1;
        y_next    = {1'b0, r_row} + 13'd1;
        row_end   = x_next >= width_c;
        frame_end = row_end && (y_next >= height_c);

        prod = 18'(r_col) * 18'(r_cfg_pbits);
        is_mono = 1'b1;
        case (r_cfg_mode)
            C_MODE_RGB16: begin
                offset  = ADDRESS_BITS'({r_col, 1'b0});
                is_mono = 1'b0;
            end
            C_MODE_RGB24: begin
                offset  = ADDRESS_BITS'(prod[17:3]);
                is_mono = 1'b0;
            end
            default: offset = ADDRESS_BITS'(r_col[11:3]);
        endcase
        addr = r_base + offset;

        code_trans = (i_pixel_code == r_cfg_trans);
        acc_set    = code_trans ? r_acc : (r_acc | (8'd1 << r_col[2:0]));
        emit       = !is_mono || (r_col[2:0] == 3'd7) || row_end;

        n_col  = r_col;
        n_row  = r_row;
        n_base = r_base;
        n_acc  = r_acc;
        if (pix_acc) begin
            if (is_mono) begin
                n_acc = emit ? 8'd0 : acc_set;
            end
            if (row_end) begin
                n_acc = 8'd0;
                n_col = 12'd0;
                if (frame_end) begin
                    n_row  = 12'd0;
                    n_base = '0;
                end else begin
                    n_row  = y_next[11:0];
                    n_base = r_base + ADDRESS_BITS'(r_cfg_stride);
                end
            end else begin
                n_col = x_next[11:0];
            end
        end

        n_s1_valid = pix_acc ? 1'b1 : (s1_go ? 1'b0 : r_s1_valid);

        if (s1_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= 12'd0;
            r_row       <= 12'd0;
            r_base      <= '0;
            r_acc       <= 8'd0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_base      <= n_base;
            r_acc       <= n_acc;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_emit      <= emit;
            r_s1_trans     <= code_trans;
            r_s1_inrange   <= (32'(i_pixel_code) < PALETTE_DEPTH);
            r_s1_mono      <= acc_set;
            r_s1_addr      <= addr;
            r_s1_row_end   <= row_end;
            r_s1_frame_end <= frame_end;
        end
    end

    always_comb begin
        color = r_s1_inrange ? ram_rdata : 24'd0;
        r5    = color[23:19];
        g5    = color[15:11];
        b5    = color[7:3];
        case (r_cfg_mode)
            C_MODE_RGB16: begin
                count = C_COUNT_RGB16;
                if (r_s1_trans) begin
                    bytes = 24'd0;
                end else if ((r5 | g5 | b5) == 5'd0) begin
                    bytes = {8'd0, C_BLACK_RGB16};
                end else begin
                    bytes = {8'd0, r5, g5[4:2], g5[1:0], 1'b0, b5};
                end
            end
            C_MODE_RGB24: begin
                count = C_COUNT_RGB24;
                if (r_s1_trans) begin
                    bytes = 24'd0;
                end else if (color == 24'd0) begin
                    bytes = C_BLACK_RGB24;
                end else begin
                    bytes = {color[23:16], color[15:8], color[7:0]};
                end
            end
            default: begin
                count = C_COUNT_MONO;
                bytes = {16'd0, r_s1_mono};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s1_load_out) begin
            r_out_addr  <= r_s1_addr;
            r_out_bytes <= bytes;
            r_out_count <= count;
            r_out_row   <= r_s1_row_end;
            r_out_frame <= r_s1_frame_end;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_byte_address = r_out_addr;
    assign o_out_bytes    = r_out_bytes;
    assign o_byte_count   = r_out_count;
    assign o_row_done     = r_out_row;
    assign o_frame_done   = r_out_frame;

endmodule

`default_nettype wire

FILE: design/ppe_chk.sv
`default_nettype none

module ppe_chk (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            o_out_valid,
    input wire logic            i_out_ready,
    input wire logic [23:0]     o_out_bytes,
    input wire ppe_pkg::t_count o_byte_count,
    input wire logic            o_row_done,
    input wire logic            o_frame_done
);

    import ppe_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_bytes)
            && $stable(o_byte_count) && $stable(o_row_done) && $stable(o_frame_done))
        else $error("stalled result changed");

    a_frame_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_done |-> o_row_done)
        else $error("frame end without row end");

    a_count_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_byte_count == C_COUNT_MONO || o_byte_count == C_COUNT_RGB16
            || o_byte_count == C_COUNT_RGB24)
        else $error("byte count of zero");

    a_unused_bytes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_count != C_COUNT_RGB24 |-> o_out_bytes[23:16] == 8'd0
            && (o_byte_count != C_COUNT_MONO || o_out_bytes[15:8] == 8'd0))
        else $error("bytes beyond byte count not zero");

endmodule

bind palette_pixel_expander ppe_chk u_ppe_chk (.*);

`default_nettype wire

FILE: tb/palette_pixel_expander_tb.sv
module palette_pixel_expander_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppe_pkg::*;

    localparam int MAX_DIM       = 4096;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [C_CFG_INDEX_W-1:0] C_REG_SPARE = 3'd7;
    localparam t_mode C_MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [25:0] addr;
        logic [23:0] bytes;
        t_count      count;
        logic        row_done;
        logic        frame_done;
    } t_result;

    localparam t_result NO_RESULT = '0;

    typedef enum logic [1:0] {STEP_PALETTE, STEP_PIXEL, STEP_REG} t_step_kind;

    typedef struct packed {
        t_step_kind  kind;
        logic [7:0]  sel;
        logic [23:0] value;
        logic        typed;
        t_result     want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [C_CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [C_CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_opcode = C_OP_PALETTE;
    logic [7:0]  i_entry_slot = '0;
    logic [7:0]  i_entry_red = '0;
    logic [7:0]  i_entry_green = '0;
    logic [7:0]  i_entry_blue = '0;
    logic [7:0]  i_pixel_code = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [25:0] o_byte_address;
    logic [23:0] o_out_bytes;
    t_count      o_byte_count;
    logic        o_row_done;
    logic        o_frame_done;

    logic [23:0] palette_rgb [256];
    bit          slot_loaded [256];
    logic [7:0]  loaded_slots [$];
    logic [11:0] col_pos = '0;
    logic [11:0] row_pos = '0;
    logic [25:0] line_base = '0;
    logic [7:0]  mono_bits = '0;

    t_mode       cfg_mode = C_MODE_RGB16;
    logic [7:0]  cfg_transparent = '0;
    logic [12:0] cfg_width = 13'd1;
    logic [12:0] cfg_height = 13'd1;
    logic [14:0] cfg_line_stride = 15'd1;
    logic [5:0]  cfg_pixel_bits = 6'd24;

    t_result     fb_writes_due [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          out_hold = 0;
    bit          in_idle_on = 1'b1;
    bit          out_idle_on = 1'b1;
    bit          item_held = 1'b0;

    t_step directed_steps [30] = '{
        '{STEP_PALETTE, 8'd0,   24'h000000, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd255, 24'hFFFFFF, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd1,   24'h070707, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd2,   24'hF80000, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd3,   24'h00FC00, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd4,   24'h0000F8, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd5,   24'h000000, 1'b0, NO_RESULT},
        '{STEP_PALETTE, 8'd170, 24'h55AA33, 1'b0, NO_RESULT},
        '{STEP_PIXEL, 8'd0,   '0, 1'b1, '{'0, 24'h000000, C_COUNT_RGB16, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd255, '0, 1'b1, '{'0, 24'h00FFDF, C_COUNT_RGB16, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd1,   '0, 1'b1, '{'0, 24'h000841, C_COUNT_RGB16, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd2,   '0, 1'b1, '{'0, 24'h00F800, C_COUNT_RGB16, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd3,   '0, 1'b1, '{'0, 24'h0007C0, C_COUNT_RGB16, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd4,   '0, 1'b1, '{'0, 24'h00001F, C_COUNT_RGB16, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd170, '0, 1'b0, NO_RESULT},
        '{STEP_REG, 8'(C_REG_SPARE), 24'h007FFF, 1'b0, NO_RESULT},
        '{STEP_REG, 8'(C_REG_OUTPUT_MODE), 24'(C_MODE_RGB24), 1'b0, NO_RESULT},
        '{STEP_PIXEL, 8'd255, '0, 1'b1, '{'0, 24'hFFFFFF, C_COUNT_RGB24, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd5,   '0, 1'b1, '{'0, 24'h010101, C_COUNT_RGB24, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd1,   '0, 1'b1, '{'0, 24'h070707, C_COUNT_RGB24, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd0,   '0, 1'b1, '{'0, 24'h000000, C_COUNT_RGB24, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd170, '0, 1'b0, NO_RESULT},
        '{STEP_REG, 8'(C_REG_OUTPUT_MODE), 24'(C_MODE_MONO), 1'b0, NO_RESULT},
        '{STEP_PIXEL, 8'd255, '0, 1'b1, '{'0, 24'h000001, C_COUNT_MONO, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd0,   '0, 1'b1, '{'0, 24'h000000, C_COUNT_MONO, 1'b1, 1'b1}},
        '{STEP_REG, 8'(C_REG_OUTPUT_MODE), 24'(C_MODE_SPARE), 1'b0, NO_RESULT},
        '{STEP_PIXEL, 8'd4,   '0, 1'b1, '{'0, 24'h000001, C_COUNT_MONO, 1'b1, 1'b1}},
        '{STEP_REG, 8'(C_REG_TRANSPARENT_INDEX), 24'd255, 1'b0, NO_RESULT},
        '{STEP_PIXEL, 8'd255, '0, 1'b1, '{'0, 24'h000000, C_COUNT_MONO, 1'b1, 1'b1}},
        '{STEP_PIXEL, 8'd0,   '0, 1'b1, '{'0, 24'h000001, C_COUNT_MONO, 1'b1, 1'b1}}
    };

    palette_pixel_expander uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_entry_slot   (i_entry_slot),
        .i_entry_red    (i_entry_red),
        .i_entry_green  (i_entry_green),
        .i_entry_blue   (i_entry_blue),
        .i_pixel_code   (i_pixel_code),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_byte_address (o_byte_address),
        .o_out_bytes    (o_out_bytes),
        .o_byte_count   (o_byte_count),
        .o_row_done     (o_row_done),
        .o_frame_done   (o_frame_done)
    );

    always #5 i_clk = ~i_clk;

    function automatic int clamp_dim(input logic [12:0] v);
        if (v == 0) begin
            return 1;
        end
        if (int'(v) > MAX_DIM) begin
            return MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic logic [12:0] draw_dim(input int small_max);
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'h1FFF;
            2: return 13'd4096;
            default: return 13'($urandom_range(1, small_max));
        endcase
    endfunction

    task automatic expand_pixel(input logic [7:0] code, output bit emit, output t_result res);
        logic [11:0] x;
        logic [7:0]  r, g, b;
        logic [4:0]  r5, g5, b5;
        bit          row_end, frame_end;
        x = col_pos;
        row_end = (int'(x) + 1) >= clamp_dim(cfg_width);
        frame_end = row_end && ((int'(row_pos) + 1) >= clamp_dim(cfg_height));
        {r, g, b} = palette_rgb[code];
        {r5, g5, b5} = {r[7:3], g[7:3], b[7:3]};
        emit = 1'b1;
        res = NO_RESULT;
        if (cfg_mode == C_MODE_RGB16) begin
            res.addr = line_base + 26'(32'(x) * 2);
            res.count = C_COUNT_RGB16;
            if (code == cfg_transparent) begin
                res.bytes = '0;
            end else if ((r5 | g5 | b5) == 0) begin
                res.bytes = 24'(C_BLACK_RGB16);
            end else begin
                res.bytes = {8'h00, r5, g5[4:2], g5[1:0], 1'b0, b5};
            end
        end else if (cfg_mode == C_MODE_RGB24) begin
            res.addr = line_base + 26'((32'(x) * 32'(cfg_pixel_bits)) >> 3);
            res.count = C_COUNT_RGB24;
            if (code == cfg_transparent) begin
                res.bytes = '0;
            end else if ((r | g | b) == 0) begin
                res.bytes = C_BLACK_RGB24;
            end else begin
                res.bytes = {r, g, b};
            end
        end else begin
            if (code != cfg_transparent) begin
                mono_bits[x[2:0]] = 1'b1;
            end
            emit = (x[2:0] == 3'd7) || row_end;
            res.addr = line_base + 26'(x >> 3);
            res.count = C_COUNT_MONO;
            res.bytes = {16'h0000, mono_bits};
            if (emit) begin
                mono_bits = '0;
            end
        end
        res.row_done = row_end;
        res.frame_done = frame_end;
        if (row_end) begin
            mono_bits = '0;
            col_pos = '0;
            if (frame_end) begin
                row_pos = '0;
                line_base = '0;
            end else begin
                row_pos = row_pos + 1'b1;
                line_base = line_base + 26'(cfg_line_stride);
            end
        end else begin
            col_pos = x + 1'b1;
        end
    endtask

    task automatic send_item(input logic op, input logic [7:0] slot, input logic [23:0] rgb,
                             input logic [7:0] code, input bit typed, input t_result want);
        bit      emit;
        t_result res;
        int      gap;
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_entry_slot <= slot;
        {i_entry_red, i_entry_green, i_entry_blue} <= rgb;
        i_pixel_code <= code;
        do @(posedge i_clk); while (!o_in_ready);
        if (op == C_OP_PALETTE) begin
            if (!slot_loaded[slot]) begin
                loaded_slots.push_back(slot);
            end
            slot_loaded[slot] = 1'b1;
            palette_rgb[slot] = rgb;
        end else begin
            expand_pixel(code, emit, res);
            if (typed) begin
                fb_writes_due.push_back(want);
            end else if (emit) begin
                fb_writes_due.push_back(res);
            end
        end
        gap = in_idle_on ? $urandom_range(0, 15) : 0;
        item_held = (gap == 0);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [C_CFG_INDEX_W-1:0] idx,
                             input logic [C_CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            C_REG_OUTPUT_MODE:       cfg_mode = data[1:0];
            C_REG_TRANSPARENT_INDEX: cfg_transparent = data[7:0];
            C_REG_IMAGE_WIDTH:       cfg_width = data[12:0];
            C_REG_IMAGE_HEIGHT:      cfg_height = data[12:0];
            C_REG_LINE_STRIDE_BYTES: cfg_line_stride = data[14:0];
            C_REG_PIXEL_STRIDE_BITS: cfg_pixel_bits = data[5:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, then wait for the pipeline to drain
    task automatic settle();
        if (item_held) begin
            i_in_valid <= 1'b0;
            item_held = 1'b0;
        end
        while (fb_writes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_fb_write();
        t_result want;
        if (fb_writes_due.size() == 0) begin
            $error("unexpected result: address %0h bytes %0h", o_byte_address, o_out_bytes);
            mismatches++;
        end else begin
            want = fb_writes_due.pop_front();
            if (o_byte_address !== want.addr) begin
                $error("byte_address: expected %0h, got %0h", want.addr, o_byte_address);
                mismatches++;
            end
            if (o_out_bytes !== want.bytes) begin
                $error("out_bytes: expected %0h, got %0h", want.bytes, o_out_bytes);
                mismatches++;
            end
            if (o_byte_count !== want.count) begin
                $error("byte_count: expected %0d, got %0d", want.count, o_byte_count);
                mismatches++;
            end
            if (o_row_done !== want.row_done) begin
                $error("row_done: expected %0b, got %0b", want.row_done, o_row_done);
                mismatches++;
            end
            if (o_frame_done !== want.frame_done) begin
                $error("frame_done: expected %0b, got %0b", want.frame_done, o_frame_done);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                compare_fb_write();
                out_hold = out_idle_on ? $urandom_range(0, 15) : 0;
            end
            if (out_hold > 0) begin
                i_out_ready <= 1'b0;
                out_hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        logic [23:0] rgb;
        logic [7:0]  code;
        int          phase_len;
        int          random_items;
        int          pick;
        random_items = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_steps[i]) begin
            case (directed_steps[i].kind)
                STEP_PALETTE: send_item(C_OP_PALETTE, directed_steps[i].sel,
                                        directed_steps[i].value, 8'($urandom),
                                        1'b0, NO_RESULT);
                STEP_PIXEL: send_item(C_OP_PIXEL, 8'($urandom), 24'($urandom),
                                      directed_steps[i].sel, directed_steps[i].typed,
                                      directed_steps[i].want);
                default: begin
                    settle();
                    write_reg(directed_steps[i].sel[C_CFG_INDEX_W-1:0],
                              directed_steps[i].value[C_CFG_DATA_W-1:0]);
                end
            endcase
        end

        while (random_items < RANDOM_ITEMS) begin
            settle();
            in_idle_on = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            write_reg(C_REG_OUTPUT_MODE, 15'($urandom_range(0, 3)));
            if ($urandom_range(0, 1) != 0) begin
                write_reg(C_REG_TRANSPARENT_INDEX, 15'($urandom_range(0, 255)));
            end else begin
                write_reg(C_REG_TRANSPARENT_INDEX,
                          15'(loaded_slots[$urandom_range(0, loaded_slots.size() - 1)]));
            end
            write_reg(C_REG_IMAGE_WIDTH, 15'(draw_dim(20)));
            write_reg(C_REG_IMAGE_HEIGHT, 15'(draw_dim(6)));
            case ($urandom_range(0, 9))
                0: write_reg(C_REG_LINE_STRIDE_BYTES, 15'd0);
                1: write_reg(C_REG_LINE_STRIDE_BYTES, 15'h7FFF);
                default: write_reg(C_REG_LINE_STRIDE_BYTES, 15'($urandom));
            endcase
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                write_reg(C_REG_PIXEL_STRIDE_BITS, 15'd24);
            end else if (pick < 9) begin
                write_reg(C_REG_PIXEL_STRIDE_BITS, 15'd32);
            end else begin
                write_reg(C_REG_PIXEL_STRIDE_BITS, 15'(6'($urandom)));
            end

            phase_len = $urandom_range(20, 80);
            repeat (phase_len) begin
                if ($urandom_range(0, 3) == 0) begin
                    case ($urandom_range(0, 9))
                        0: rgb = '0;
                        1: rgb = {5'd0, 3'($urandom), 5'd0, 3'($urandom), 5'd0, 3'($urandom)};
                        2: rgb = 24'hFFFFFF;
                        default: rgb = 24'($urandom);
                    endcase
                    send_item(C_OP_PALETTE, 8'($urandom), rgb, 8'($urandom), 1'b0, NO_RESULT);
                end else begin
                    if (slot_loaded[cfg_transparent] && $urandom_range(0, 6) == 0) begin
                        code = cfg_transparent;
                    end else begin
                        code = loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
                    end
                    send_item(C_OP_PIXEL, 8'($urandom), 24'($urandom), code, 1'b0, NO_RESULT);
                end
                random_items++;
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
